FILE: sv/gbfs_pkg.sv
// shared types, constants and helpers for the grid bfs visit order unit
`timescale 1ns / 1ps

package gbfs_pkg;

    localparam int COORD_W      = 3;
    localparam int CELL_W       = 2 * COORD_W;
    localparam int SIZE_W       = 4;
    localparam int GRID_SLOTS   = 1 << COORD_W;
    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;
    localparam int NUM_DIRS     = 4;
    localparam int STEP_W       = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic [0:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    // neighbor order: right, left, up, down
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAD,
        S_CLEAR,
        S_SEED,
        S_EMIT,
        S_NBR
    } t_state;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_nbr;

    function automatic t_nbr nbr_of(t_dir dir, logic [COORD_W-1:0] row,
                                    logic [COORD_W-1:0] col,
                                    logic [SIZE_W-1:0] nr, logic [SIZE_W-1:0] nc);
        t_nbr n;
        n.ok  = 1'b0;
        n.row = row;
        n.col = col;
        case (dir)
            DIR_RIGHT: begin
                n.col = col + 3'd1;
                n.ok  = ({1'b0, col} + 4'd1) < nc;
            end
            DIR_LEFT: begin
                n.col = col - 3'd1;
                n.ok  = col != 3'd0;
            end
            DIR_UP: begin
                n.row = row - 3'd1;
                n.ok  = row != 3'd0;
            end
            DIR_DOWN: begin
                n.row = row + 3'd1;
                n.ok  = ({1'b0, row} + 4'd1) < nr;
            end
            default: begin
                n.ok = 1'b0;
            end
        endcase
        return n;
    endfunction

endpackage

FILE: sv/gbfs_in_if.sv
// start cell channel
`timescale 1ns / 1ps

interface gbfs_in_if;
    import gbfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;

    modport source (output valid, output start_row, output start_col, input ready);
    modport sink   (input valid, input start_row, input start_col, output ready);
endinterface

FILE: sv/gbfs_out_if.sv
// visited cell result channel
`timescale 1ns / 1ps

interface gbfs_out_if;
    import gbfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               last;
    logic               bad_start;

    modport source (output valid, output cell_row, output cell_col, output last,
                    output bad_start, input ready);
    modport sink   (input valid, input cell_row, input cell_col, input last,
                    input bad_start, output ready);
endinterface

FILE: sv/grid_bfs_visit_order_unit.sv
// grid bfs visit order unit: seen-row memory, cell queue memory and walk sequencer
// per cell: one queue read, four neighbor seen-row reads with read-modify-write, one drain
// the next start is taken on return to idle
// the seen-row memory is swept clear (8 rows) at the start of every walk
// synchronous active-low reset: sizes back to 8, sequencer idle, queue pointers zero, no result
`timescale 1ns / 1ps

module grid_bfs_visit_order_unit #(
    parameter int MAX_ROWS = gbfs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gbfs_pkg::MAX_COLS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gbfs_in_if.sink                   i_in,
    gbfs_out_if.source                o_out,
    input  logic                      i_cfg_we,
    input  gbfs_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [gbfs_pkg::SIZE_W-1:0] i_cfg_data
);
    import gbfs_pkg::*;

    localparam int QDEPTH = MAX_ROWS * MAX_COLS;
    localparam int PW     = $clog2(QDEPTH + 1);
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [SIZE_W-1:0] ROWS_CAP = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] COLS_CAP = SIZE_W'(MAX_COLS);
    localparam logic [STEP_W-1:0] STEP_END = STEP_W'(NUM_DIRS);

    // memories
    logic [GRID_SLOTS-1:0] seen_mem  [GRID_SLOTS];
    logic [CELL_W-1:0]     queue_mem [QDEPTH];

    logic [GRID_SLOTS-1:0] r_seen_q;
    logic [CELL_W-1:0]     r_q_data;

    logic                  seen_re, seen_we, q_re, q_we;
    logic [COORD_W-1:0]    seen_ra, seen_wa;
    logic [GRID_SLOTS-1:0] seen_wd;
    logic [QAW-1:0]        q_ra, q_wa;
    logic [CELL_W-1:0]     q_wd;

    // registers
    t_state                r_state, n_state;
    logic [SIZE_W-1:0]     r_rows, r_cols;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [COORD_W-1:0]    r_clr, n_clr;
    logic [PW-1:0]         r_head, n_head, r_tail, n_tail;
    logic [CELL_W-1:0]     r_start, n_start;
    logic                  r_have_out, n_have_out;
    logic                  r_pend_ok, n_pend_ok;
    logic [COORD_W-1:0]    r_pend_row, n_pend_row, r_pend_col, n_pend_col;
    logic                  r_fwd_ok;
    logic [COORD_W-1:0]    r_fwd_row;
    logic [GRID_SLOTS-1:0] r_fwd_data;
    logic                  r_out_valid, n_out_valid;
    logic [COORD_W-1:0]    r_out_row, n_out_row, r_out_col, n_out_col;
    logic                  r_out_last, n_out_last, r_out_bad, n_out_bad;

    logic [SIZE_W-1:0]     eff_rows, eff_cols;
    logic                  in_acc, start_bad, out_free, pend_new;
    logic [COORD_W-1:0]    cur_row, cur_col;
    logic [GRID_SLOTS-1:0] row_bits;
    t_nbr                  nbr;

    assign eff_rows  = (r_rows > ROWS_CAP) ? ROWS_CAP : r_rows;
    assign eff_cols  = (r_cols > COLS_CAP) ? COLS_CAP : r_cols;
    assign in_acc    = i_in.valid && i_in.ready;
    assign start_bad = ({1'b0, i_in.start_row} >= eff_rows) ||
                       ({1'b0, i_in.start_col} >= eff_cols);
    assign out_free  = !r_out_valid || o_out.ready;
    assign cur_row   = r_q_data[CELL_W-1:COORD_W];
    assign cur_col   = r_q_data[COORD_W-1:0];
    assign nbr       = nbr_of(t_dir'(r_step[1:0]), cur_row, cur_col, eff_rows, eff_cols);

    // row written in the same cycle as the read is not in the read data yet
    assign row_bits  = (r_fwd_ok && (r_fwd_row == r_pend_row)) ? r_fwd_data : r_seen_q;
    assign pend_new  = r_pend_ok && !row_bits[r_pend_col];

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.cell_row  = r_out_row;
    assign o_out.cell_col  = r_out_col;
    assign o_out.last      = r_out_last;
    assign o_out.bad_start = r_out_bad;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_clr       = r_clr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_start     = r_start;
        n_have_out  = r_have_out;
        n_pend_ok   = r_pend_ok;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        seen_re     = 1'b0;
        seen_ra     = nbr.row;
        seen_we     = 1'b0;
        seen_wa     = r_pend_row;
        seen_wd     = row_bits;
        q_re        = 1'b0;
        q_ra        = r_head[QAW-1:0];
        q_we        = 1'b0;
        q_wa        = r_tail[QAW-1:0];
        q_wd        = {r_pend_row, r_pend_col};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (start_bad) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_row   = '0;
                            n_out_col   = '0;
                            n_out_last  = 1'b1;
                            n_out_bad   = 1'b1;
                        end else begin
                            n_state = S_BAD;
                        end
                    end else begin
                        n_start = {i_in.start_row, i_in.start_col};
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end
                end
            end
            S_BAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = '0;
                    n_out_col   = '0;
                    n_out_last  = 1'b1;
                    n_out_bad   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_CLEAR: begin
                seen_we = 1'b1;
                seen_wa = r_clr;
                seen_wd = '0;
                n_clr   = r_clr + COORD_W'(1);
                if (&r_clr) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                seen_we    = 1'b1;
                seen_wa    = r_start[CELL_W-1:COORD_W];
                seen_wd    = GRID_SLOTS'(1) << r_start[COORD_W-1:0];
                q_we       = 1'b1;
                q_wa       = '0;
                q_wd       = r_start;
                n_head     = '0;
                n_tail     = PW'(1);
                n_have_out = 1'b0;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // hand over the finished cell and dequeue the next one
                if (!r_have_out || out_free) begin
                    if (r_have_out) begin
                        n_out_valid = 1'b1;
                        n_out_row   = cur_row;
                        n_out_col   = cur_col;
                        n_out_last  = (r_head == r_tail);
                        n_out_bad   = 1'b0;
                    end
                    if (r_have_out && (r_head == r_tail)) begin
                        n_state = S_IDLE;
                    end else begin
                        q_re    = 1'b1;
                        n_head  = r_head + PW'(1);
                        n_step  = '0;
                        n_state = S_NBR;
                    end
                end
            end
            S_NBR: begin
                if (r_step != STEP_END) begin
                    seen_re    = 1'b1;
                    n_pend_ok  = nbr.ok;
                    n_pend_row = nbr.row;
                    n_pend_col = nbr.col;
                end
                if ((r_step != '0) && pend_new) begin
                    seen_we = 1'b1;
                    seen_wd = row_bits | (GRID_SLOTS'(1) << r_pend_col);
                    q_we    = 1'b1;
                    n_tail  = r_tail + PW'(1);
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_END) begin
                    n_have_out = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= SIZE_RESET;
            r_cols      <= SIZE_RESET;
            r_step      <= '0;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_have_out  <= 1'b0;
            r_pend_ok   <= 1'b0;
            r_fwd_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_have_out  <= n_have_out;
            r_pend_ok   <= n_pend_ok;
            r_fwd_ok    <= seen_we;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_pend_row <= n_pend_row;
        r_pend_col <= n_pend_col;
        r_fwd_row  <= seen_wa;
        r_fwd_data <= seen_wd;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    // seen-row memory, one row of flags per grid row
    always_ff @(posedge i_clk) begin
        if (seen_we) begin
            seen_mem[seen_wa] <= seen_wd;
        end
        if (seen_re) begin
            r_seen_q <= seen_mem[seen_ra];
        end
    end

    // cell queue memory
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_mem[q_wa] <= q_wd;
        end
        if (q_re) begin
            r_q_data <= queue_mem[q_ra];
        end
    end

`ifndef NO_ASSERTIONS
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= PW'(QDEPTH))
        else $error("queue tail beyond depth");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_start) |-> o_out.last)
        else $error("bad start result not marked last");

    a_walk_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_IDLE) |=> (r_out_valid && r_out_last))
        else $error("walk ended without final result");

    a_enqueue_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_we && r_state == S_NBR) |-> (r_tail < PW'(QDEPTH)))
        else $error("enqueue into full queue");
`endif

endmodule

FILE: sim/grid_bfs_visit_order_unit_test.sv
// testbench for the grid bfs visit order unit: predicted walks checked cell by cell
`timescale 1ns / 1ps

module grid_bfs_visit_order_unit_test;
    import gbfs_pkg::*;

    localparam int RANDOM_STARTS = 400;
    localparam int CYCLE_LIMIT   = 1200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int IDLE_PCT      = 14;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
        logic               bad;
    } t_visit;

    // keeps the grid size the block should be using and the cells it still owes
    class t_walk_board;
        logic [SIZE_W-1:0] grid_rows;
        logic [SIZE_W-1:0] grid_cols;
        t_visit            pending_cells[$];
        int                starts;
        int                bad_starts;
        int                cells_checked;
        int                failures;

        function new();
            grid_rows     = SIZE_RESET;
            grid_cols     = SIZE_RESET;
            starts        = 0;
            bad_starts    = 0;
            cells_checked = 0;
            failures      = 0;
        endfunction

        function void set_size(t_cfg_idx idx, logic [SIZE_W-1:0] val);
            case (idx)
                CFG_ROWS: grid_rows = val;
                CFG_COLS: grid_cols = val;
                default: ;
            endcase
        endfunction

        function void miss(string msg);
            failures++;
            if (failures <= 10) $display("MISMATCH: %s", msg);
        endfunction

        // breadth-first walk from the accepted start, queued in visit order
        function void add_walk(logic [COORD_W-1:0] sr, logic [COORD_W-1:0] sc);
            int         nr, nc, head, tail, d, ni, nj;
            bit         seen[64];
            logic [5:0] order[64];
            logic [5:0] cur, slot;
            t_visit     v;
            starts++;
            nr = (grid_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(grid_rows);
            nc = (grid_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(grid_cols);
            if (int'(sr) >= nr || int'(sc) >= nc) begin
                bad_starts++;
                v = '{row: '0, col: '0, last: 1'b1, bad: 1'b1};
                pending_cells.push_back(v);
                return;
            end
            foreach (seen[i]) seen[i] = 1'b0;
            order[0] = {sr, sc};
            seen[{sr, sc}] = 1'b1;
            head = 0;
            tail = 1;
            while (head != tail && head < 64) begin
                cur = order[head];
                head++;
                for (d = 0; d < NUM_DIRS; d++) begin
                    ni = int'(cur[5:3]);
                    nj = int'(cur[2:0]);
                    case (t_dir'(d))
                        DIR_RIGHT: nj = nj + 1;
                        DIR_LEFT:  nj = nj - 1;
                        DIR_UP:    ni = ni - 1;
                        DIR_DOWN:  ni = ni + 1;
                        default: ;
                    endcase
                    if (ni < 0 || nj < 0 || ni >= nr || nj >= nc || tail >= 64) continue;
                    slot = {ni[2:0], nj[2:0]};
                    if (seen[slot]) continue;
                    seen[slot]  = 1'b1;
                    order[tail] = slot;
                    tail++;
                end
                v.row  = cur[5:3];
                v.col  = cur[2:0];
                v.last = (head == tail);
                v.bad  = 1'b0;
                pending_cells.push_back(v);
            end
        endfunction

        function void check_cell(t_visit got);
            t_visit want;
            if (pending_cells.size() == 0) begin
                miss($sformatf("unexpected cell row %0d col %0d last %0d bad %0d",
                               got.row, got.col, got.last, got.bad));
                return;
            end
            want = pending_cells.pop_front();
            cells_checked++;
            if (got.row !== want.row || got.col !== want.col || got.last !== want.last ||
                got.bad !== want.bad)
                miss({$sformatf("cell %0d: expected row %0d col %0d last %0d bad %0d, ",
                                cells_checked, want.row, want.col, want.last, want.bad),
                      $sformatf("got row %0d col %0d last %0d bad %0d",
                                got.row, got.col, got.last, got.bad)});
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    t_cfg_idx          cfg_idx;
    logic [SIZE_W-1:0] cfg_data;
    bit                no_idle;
    int                cycles = 0;
    int                grid_settings;
    t_walk_board       board;

    gbfs_in_if  in_ch();
    gbfs_out_if out_ch();

    grid_bfs_visit_order_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls at random except during the no-idle stretch
    always @(negedge i_clk) begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_cell('{row: out_ch.cell_row, col: out_ch.cell_col,
                               last: out_ch.last, bad: out_ch.bad_start});
    end

    // valid stays high across back-to-back transactions; dropped only while idling
    task automatic send_start(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.start_row <= r;
        in_ch.start_col <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.add_walk(r, c);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (board.pending_cells.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_grid(logic [SIZE_W-1:0] r, logic [SIZE_W-1:0] c);
        wait_drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ROWS;
        cfg_data <= r;
        @(negedge i_clk);
        board.set_size(CFG_ROWS, r);
        cfg_idx  <= CFG_COLS;
        cfg_data <= c;
        @(negedge i_clk);
        board.set_size(CFG_COLS, c);
        cfg_we <= 1'b0;
        grid_settings++;
    endtask

    initial begin
        int                sent, n, k, sel, nr, nc;
        logic [SIZE_W-1:0] r, c;
        logic [COORD_W-1:0] sr, sc;

        board           = new();
        grid_settings   = 0;
        no_idle         = 1'b0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_ROWS;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.start_row = '0;
        in_ch.start_col = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset size, three corners of the full grid and one inner cell
        send_start(3'd0, 3'd0);
        send_start(3'd7, 3'd7);
        send_start(3'd0, 3'd7);
        send_start(3'd5, 3'd2);
        // odd shape, starts outside by row, by column and both
        set_grid(4'd3, 4'd5);
        send_start(3'd2, 3'd4);
        send_start(3'd3, 3'd0);
        send_start(3'd0, 3'd5);
        send_start(3'd7, 3'd7);
        // single cell grid
        set_grid(4'd1, 4'd1);
        send_start(3'd0, 3'd0);
        send_start(3'd0, 3'd1);
        // sizes above the maximum saturate
        set_grid(4'd15, 4'd12);
        send_start(3'd7, 3'd7);
        send_start(3'd0, 3'd3);
        // zero rows or zero columns: nothing is inside
        set_grid(4'd0, 4'd4);
        send_start(3'd0, 3'd0);
        set_grid(4'd4, 4'd0);
        send_start(3'd0, 3'd0);
        // one row, one column
        set_grid(4'd1, 4'd8);
        send_start(3'd0, 3'd3);
        set_grid(4'd8, 4'd1);
        send_start(3'd4, 3'd0);

        sent = 0;
        while (sent < RANDOM_STARTS) begin
            sel = $urandom_range(0, 15);
            if (sel == 0) begin
                r = 4'd8;
                c = 4'd8;
            end else if (sel == 1) begin
                r = $urandom_range(0, 1) ? 4'd0 : 4'(($urandom_range(9, 15)));
                c = 4'($urandom_range(0, 15));
            end else if (sel == 2) begin
                r = 4'($urandom_range(1, 8));
                c = 4'($urandom_range(9, 15));
            end else begin
                r = 4'($urandom_range(1, 5));
                c = 4'($urandom_range(1, 5));
            end
            set_grid(r, c);
            nr = (r > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(r);
            nc = (c > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(c);
            n  = (sel == 0) ? $urandom_range(2, 5) : $urandom_range(8, 24);
            for (k = 0; k < n && sent < RANDOM_STARTS; k++) begin
                no_idle = (sent >= 150 && sent < 210);
                if (sent == RANDOM_STARTS / 2) wait_drain();
                if (nr > 0 && nc > 0 && $urandom_range(0, 9) < 8) begin
                    sr = 3'($urandom_range(0, nr - 1));
                    sc = 3'($urandom_range(0, nc - 1));
                end else begin
                    sr = 3'($urandom_range(0, 7));
                    sc = 3'($urandom_range(0, 7));
                end
                send_start(sr, sc);
                sent++;
            end
        end
        no_idle = 1'b0;

        in_ch.valid <= 1'b0;
        while (board.pending_cells.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.pending_cells.size() != 0)
            board.miss($sformatf("%0d cells never arrived", board.pending_cells.size()));

        $display("walks started: %0d (%0d outside the grid) over %0d grid sizes",
                 board.starts, board.bad_starts, grid_settings);
        $display("visited cells checked: %0d, mismatches: %0d",
                 board.cells_checked, board.failures);
        if (board.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
